>>> hdl/spfs_pkg.sv
package spfs_pkg;

    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 24;
    localparam int WAIT_W   = 12;
    localparam int MAXW_W   = 11;
    localparam int OCC_W    = 7;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_SERVE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_QUEUED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SERVED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd3;

    localparam int MINUTES_PER_HOUR = 60;
    localparam int WAIT_LIMIT       = 1439;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;
    localparam int SMALL_MAX        = 127;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the input beat and start the head read
        logic commit;  // update queue state and load the result register
    } spfs_cmd_t;

endpackage

>>> hdl/spfs_ctrl.sv
module spfs_ctrl
    import spfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output spfs_cmd_t cmd
);

    typedef enum logic {
        IDLE,
        EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   load;
    logic   commit;

    assign in_ready  = (state_reg == IDLE);
    assign out_valid = out_valid_reg;
    assign load      = in_valid && (state_reg == IDLE);
    // The result register must be free, or emptied in this cycle, before the commit.
    assign commit    = (state_reg == EXEC) && (!out_valid_reg || out_ready);

    assign cmd.load   = load;
    assign cmd.commit = commit;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (load)
                begin
                    state_next = EXEC;
                end
            end
            EXEC:
            begin
                if (commit)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/spfs_dp.sv
module spfs_dp
    import spfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_LEVELS  = 4,
    parameter int TICKET_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  spfs_cmd_t                  cmd,
    input  logic                       command,
    input  logic [15:0]                ticket,
    input  logic [1:0]                 level,
    input  logic [HOUR_W-1:0]          hour,
    input  logic [MIN_W-1:0]           minute,
    output logic [STATUS_W-1:0]        status,
    output logic [15:0]                served_ticket,
    output logic [1:0]                 served_level,
    output logic signed [WAIT_W-1:0]   wait_minutes,
    output logic [COUNT_W-1:0]         total_served,
    output logic [COUNT_W-1:0]         level_served,
    output logic [MAXW_W-1:0]          max_wait,
    output logic [OCC_W-1:0]           peak_occupancy,
    output logic [OCC_W-1:0]           occupancy
);

    localparam int LVL_W   = $clog2(NUM_LEVELS);
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int TOT_W   = $clog2(NUM_LEVELS * QUEUE_DEPTH + 1);
    localparam int ENTRY_W = TICKET_BITS + HOUR_W + MIN_W;
    localparam int MEM_DEPTH = 2 ** (LVL_W + PTR_W);

    logic [ENTRY_W-1:0] mem [MEM_DEPTH];

    logic [PTR_W-1:0]   head_reg  [NUM_LEVELS];
    logic [PTR_W-1:0]   tail_reg  [NUM_LEVELS];
    logic [CNT_W-1:0]   count_reg [NUM_LEVELS];
    logic [COUNT_W-1:0] lvl_served_reg [NUM_LEVELS];
    logic [TOT_W-1:0]   total_reg;
    logic [TOT_W-1:0]   peak_reg;
    logic [COUNT_W-1:0] served_reg;
    logic [MAXW_W-1:0]  max_wait_reg;

    // Input beat, captured at the accept and held until the commit.
    logic                   cmd_reg;
    logic [TICKET_BITS-1:0] ticket_reg;
    logic [1:0]             level_reg;
    logic [HOUR_W-1:0]      hour_reg;
    logic [MIN_W-1:0]       minute_reg;
    logic                   sel_valid_reg;
    logic [LVL_W-1:0]       sel_lvl_reg;
    logic [ENTRY_W-1:0]     rd_data_reg;

    // Result register.
    logic [STATUS_W-1:0]      status_reg;
    logic [15:0]              s_ticket_reg;
    logic [1:0]               s_level_reg;
    logic signed [WAIT_W-1:0] s_wait_reg;
    logic [COUNT_W-1:0]       out_total_reg;
    logic [COUNT_W-1:0]       out_lvl_reg;
    logic [MAXW_W-1:0]        out_max_reg;
    logic [OCC_W-1:0]         out_peak_reg;
    logic [OCC_W-1:0]         out_occ_reg;

    logic                   sel_any;
    logic [LVL_W-1:0]       sel_lvl;
    logic [LVL_W-1:0]       arr_lvl;
    logic                   arr_ok;
    logic                   do_push;
    logic                   do_pop;
    logic [TICKET_BITS-1:0] e_ticket;
    logic [HOUR_W-1:0]      e_hour;
    logic [MIN_W-1:0]       e_minute;
    logic signed [6:0]      hr_diff;
    logic signed [6:0]      mn_diff;
    logic signed [13:0]     w_raw;
    logic signed [WAIT_W-1:0] w_sat;
    logic [TOT_W-1:0]       total_next;
    logic [TOT_W-1:0]       peak_next;
    logic [COUNT_W-1:0]     served_next;
    logic [COUNT_W-1:0]     lvl_served_next;
    logic [MAXW_W-1:0]      max_wait_next;
    logic [STATUS_W-1:0]    status_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [OCC_W-1:0] sat_occ(input logic [TOT_W-1:0] v);
        logic [31:0] ext;
        ext = 32'(v);
        return (ext > 32'(SMALL_MAX)) ? OCC_W'(SMALL_MAX) : OCC_W'(ext);
    endfunction

    // Highest-priority non-empty queue, from the counts left by the last item.
    always_comb
    begin
        sel_any = 1'b0;
        sel_lvl = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                sel_any = 1'b1;
                sel_lvl = LVL_W'(i);
            end
        end
    end

    assign arr_lvl = LVL_W'(level_reg);
    assign arr_ok  = (32'(level_reg) < 32'(NUM_LEVELS))
                     && (count_reg[arr_lvl] != CNT_W'(QUEUE_DEPTH));
    assign do_push = cmd.commit && (cmd_reg == CMD_ARRIVE) && arr_ok;
    assign do_pop  = cmd.commit && (cmd_reg == CMD_SERVE) && sel_valid_reg;

    assign {e_ticket, e_hour, e_minute} = rd_data_reg;

    always_comb
    begin
        hr_diff = $signed({2'b00, hour_reg}) - $signed({2'b00, e_hour});
        mn_diff = $signed({1'b0, minute_reg}) - $signed({1'b0, e_minute});
        w_raw   = 14'(hr_diff) * 14'(MINUTES_PER_HOUR) + 14'(mn_diff);
        if (w_raw > 14'(WAIT_LIMIT))
        begin
            w_sat = WAIT_W'(WAIT_LIMIT);
        end
        else if (w_raw < -14'(WAIT_LIMIT))
        begin
            w_sat = -WAIT_W'(WAIT_LIMIT);
        end
        else
        begin
            w_sat = WAIT_W'(w_raw);
        end
    end

    always_comb
    begin
        total_next      = total_reg;
        peak_next       = peak_reg;
        served_next     = served_reg;
        lvl_served_next = lvl_served_reg[sel_lvl_reg];
        max_wait_next   = max_wait_reg;
        if (cmd_reg == CMD_ARRIVE)
        begin
            status_next = arr_ok ? ST_QUEUED : ST_DROPPED;
            if (arr_ok)
            begin
                total_next = total_reg + 1'b1;
                if (total_next > peak_reg)
                begin
                    peak_next = total_next;
                end
            end
        end
        else if (sel_valid_reg)
        begin
            status_next = ST_SERVED;
            total_next  = total_reg - 1'b1;
            if (served_reg != COUNT_MAX)
            begin
                served_next = served_reg + 1'b1;
            end
            if (lvl_served_reg[sel_lvl_reg] != COUNT_MAX)
            begin
                lvl_served_next = lvl_served_reg[sel_lvl_reg] + 1'b1;
            end
            // A negative wait never raises the maximum.
            if ((w_sat > 0) && (MAXW_W'(w_sat) > max_wait_reg))
            begin
                max_wait_next = MAXW_W'(w_sat);
            end
        end
        else
        begin
            status_next = ST_EMPTY;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[{arr_lvl, tail_reg[arr_lvl]}] <= {ticket_reg, hour_reg, minute_reg};
        end
        if (cmd.load)
        begin
            rd_data_reg <= mem[{sel_lvl, head_reg[sel_lvl]}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg       <= command;
            ticket_reg    <= TICKET_BITS'(ticket);
            level_reg     <= level;
            hour_reg      <= hour;
            minute_reg    <= minute;
            sel_valid_reg <= sel_any;
            sel_lvl_reg   <= sel_lvl;
        end
        if (cmd.commit)
        begin
            status_reg    <= status_next;
            out_total_reg <= served_next;
            out_max_reg   <= max_wait_next;
            out_peak_reg  <= sat_occ(peak_next);
            out_occ_reg   <= sat_occ(total_next);
            if (status_next == ST_SERVED)
            begin
                s_ticket_reg <= 16'(e_ticket);
                s_level_reg  <= 2'(sel_lvl_reg);
                s_wait_reg   <= w_sat;
                out_lvl_reg  <= lvl_served_next;
            end
            else
            begin
                s_ticket_reg <= '0;
                s_level_reg  <= '0;
                s_wait_reg   <= '0;
                out_lvl_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]       <= '0;
                tail_reg[i]       <= '0;
                count_reg[i]      <= '0;
                lvl_served_reg[i] <= '0;
            end
            total_reg    <= '0;
            peak_reg     <= '0;
            served_reg   <= '0;
            max_wait_reg <= '0;
        end
        else if (cmd.commit)
        begin
            total_reg    <= total_next;
            peak_reg     <= peak_next;
            served_reg   <= served_next;
            max_wait_reg <= max_wait_next;
            if (do_push)
            begin
                tail_reg[arr_lvl]  <= ptr_inc(tail_reg[arr_lvl]);
                count_reg[arr_lvl] <= count_reg[arr_lvl] + 1'b1;
            end
            if (do_pop)
            begin
                head_reg[sel_lvl_reg]       <= ptr_inc(head_reg[sel_lvl_reg]);
                count_reg[sel_lvl_reg]      <= count_reg[sel_lvl_reg] - 1'b1;
                lvl_served_reg[sel_lvl_reg] <= lvl_served_next;
            end
        end
    end

    assign status         = status_reg;
    assign served_ticket  = s_ticket_reg;
    assign served_level   = s_level_reg;
    assign wait_minutes   = s_wait_reg;
    assign total_served   = out_total_reg;
    assign level_served   = out_lvl_reg;
    assign max_wait       = out_max_reg;
    assign peak_occupancy = out_peak_reg;
    assign occupancy      = out_occ_reg;

endmodule

>>> hdl/strict_priority_fifo_scheduler_top.sv
// Channel   Handshake              Beat contents
// input     in_valid / in_ready    command, ticket, level, hour, minute
// output    out_valid / out_ready  status, served_ticket, served_level, wait_minutes,
//                                  total_served, level_served, max_wait,
//                                  peak_occupancy, occupancy
//
// For every item the accept edge reads the head entry of the
// highest-priority non-empty queue from the entry memory, and the commit edge
// updates pointers, counts and statistics and loads the result register.
// An item is accepted while a previous result still waits in the result register.
// The commit stalls while that register is full and out_ready is low.
// Reset clears pointers, counts and statistics at once; the entry memory is not cleared.
module strict_priority_fifo_scheduler_top
    import spfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_LEVELS  = 4,
    parameter int TICKET_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     command,
    input  logic [15:0]              ticket,
    input  logic [1:0]               level,
    input  logic [HOUR_W-1:0]        hour,
    input  logic [MIN_W-1:0]         minute,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [15:0]              served_ticket,
    output logic [1:0]               served_level,
    output logic signed [WAIT_W-1:0] wait_minutes,
    output logic [COUNT_W-1:0]       total_served,
    output logic [COUNT_W-1:0]       level_served,
    output logic [MAXW_W-1:0]        max_wait,
    output logic [OCC_W-1:0]         peak_occupancy,
    output logic [OCC_W-1:0]         occupancy
);

    spfs_cmd_t cmd;

    spfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    spfs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_LEVELS  (NUM_LEVELS),
        .TICKET_BITS (TICKET_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .command        (command),
        .ticket         (ticket),
        .level          (level),
        .hour           (hour),
        .minute         (minute),
        .status         (status),
        .served_ticket  (served_ticket),
        .served_level   (served_level),
        .wait_minutes   (wait_minutes),
        .total_served   (total_served),
        .level_served   (level_served),
        .max_wait       (max_wait),
        .peak_occupancy (peak_occupancy),
        .occupancy      (occupancy)
    );

endmodule

>>> hdl/spfs_checker.sv
module spfs_checker
    import spfs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [STATUS_W-1:0]      status,
    input logic signed [WAIT_W-1:0] wait_minutes,
    input logic [MAXW_W-1:0]        max_wait,
    input logic [OCC_W-1:0]         peak_occupancy,
    input logic [OCC_W-1:0]         occupancy
);

    // A result beat that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat withdrawn before it was taken");

    // Items are never accepted back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on two consecutive cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> (occupancy == '0))
        else $error("empty status with entries still waiting");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_SERVED) && !wait_minutes[WAIT_W-1]
        |-> (max_wait >= MAXW_W'(wait_minutes)))
        else $error("served wait exceeds the reported maximum");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_QUEUED) |-> (peak_occupancy >= occupancy))
        else $error("peak occupancy below current occupancy after an arrival");

endmodule

bind strict_priority_fifo_scheduler_top spfs_checker u_spfs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .wait_minutes   (wait_minutes),
    .max_wait       (max_wait),
    .peak_occupancy (peak_occupancy),
    .occupancy      (occupancy)
);
